@@ rtl/ws_pbe_pkg.sv @@
// Shared types and constants of the pixel bit encoder.
// Used by ws_pbe_store and ws2812_pixel_bit_encoder; depends on nothing else.
package ws_pbe_pkg;

  localparam int MAX_PIXELS     = 64;
  localparam int PIX_AW         = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int BITS_PER_PIXEL = 24;
  localparam int COLOR_W        = 24;
  localparam int DUTY_W         = 8;
  localparam int CNT_W          = 7;
  localparam int GAP_MAX        = 255;
  localparam int SLOT_W         = $clog2(2 * GAP_MAX + BITS_PER_PIXEL * MAX_PIXELS + 1);
  localparam int DIV_K          = SLOT_W;
  localparam int RECIP3         = (2 ** DIV_K + 2) / 3;
  localparam int CFG_IDX_W      = 3;

  localparam logic [CFG_IDX_W-1:0] REG_DUTY_ONE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_ZERO   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_COUNT = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_LEAD_SLOTS  = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_TRAIL_SLOTS = CFG_IDX_W'(4);

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_FILL  = 2'd1,
    OP_START = 2'd2,
    OP_FETCH = 2'd3
  } ws_op_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [5:0]         pixel_index;
    logic [COLOR_W-1:0] color_grb;
  } cmd_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty_code;
    logic              frame_end;
  } result_t;

  typedef struct packed {
    logic               wr_en;
    logic               fill_en;
    logic               rd_en;
    logic [PIX_AW-1:0]  wr_addr;
    logic [PIX_AW-1:0]  rd_addr;
    logic [COLOR_W-1:0] color;
  } mem_req_t;

endpackage

@@ rtl/ws_pbe_store.sv @@
// Pixel color store: a synchronous memory, per-pixel written flags and the fill color.
// Depends on ws_pbe_pkg for the request type and sizes.
module ws_pbe_store (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ws_pbe_pkg::mem_req_t         req_i,
  output logic [ws_pbe_pkg::COLOR_W-1:0] color_o
);

  logic [ws_pbe_pkg::COLOR_W-1:0]    mem_q [ws_pbe_pkg::MAX_PIXELS];
  logic [ws_pbe_pkg::COLOR_W-1:0]    rd_data_q;
  logic [ws_pbe_pkg::MAX_PIXELS-1:0] written_q;
  logic [ws_pbe_pkg::MAX_PIXELS-1:0] written_d;
  logic                              hit_q;
  logic [ws_pbe_pkg::COLOR_W-1:0]    fill_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.color;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr];
    end
  end

  always_comb begin
    written_d = written_q;
    if (req_i.fill_en) begin
      written_d = '0;
    end
    if (req_i.wr_en) begin
      written_d[req_i.wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      fill_q    <= '0;
      hit_q     <= 1'b0;
    end else begin
      written_q <= written_d;
      if (req_i.fill_en) begin
        fill_q <= req_i.color;
      end
      if (req_i.rd_en) begin
        hit_q <= written_q[req_i.rd_addr];
      end
    end
  end

  assign color_o = hit_q ? rd_data_q : fill_q;

endmodule

@@ rtl/ws2812_pixel_bit_encoder.sv @@
// A fetch result appears in the cycle after its transfer; other commands give none.
// Throughput: one command per cycle; busy stays low, as the pixel store read is pipelined.
// The color comes from a synchronous memory read in the transfer cycle.
// Reset clears the configuration to its defaults and shows every pixel as black.
// The receiver cannot stall, so each result is shown for exactly one cycle.
module ws2812_pixel_bit_encoder (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  ws_pbe_pkg::cmd_t                 data_i,
  output logic                             result_valid_o,
  output ws_pbe_pkg::result_t              result_o,
  input  logic                             cfg_we_i,
  input  logic [ws_pbe_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [7:0]                       cfg_wdata_i
);

  localparam int SW = ws_pbe_pkg::SLOT_W;

  logic [ws_pbe_pkg::DUTY_W-1:0] duty_one_q, duty_zero_q;
  logic [ws_pbe_pkg::CNT_W-1:0]  pix_cnt_q;
  logic [7:0]                    lead_q, trail_q;

  logic [SW-1:0] slot_q, slot_d;
  logic          active_q, active_d;
  logic          pend_q, code_en_q, end_q;
  logic [4:0]    bit_q;

  logic                         accept, fetch_go;
  logic [ws_pbe_pkg::CNT_W-1:0] live_pix;
  logic [SW-1:0]                pix_bits, frame_len, rel, bit_full;
  logic [SW:0]                  slot_inc;
  logic                         is_last, in_pix;
  logic [2*SW-1:0]              quot_prod;
  logic [SW-1:0]                pix_idx;
  logic [ws_pbe_pkg::COLOR_W-1:0] color, color_sh;
  ws_pbe_pkg::mem_req_t         mem_req;

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign fetch_go = accept && (data_i.opcode == ws_pbe_pkg::OP_FETCH);

  always_comb begin
    live_pix  = (32'(pix_cnt_q) > ws_pbe_pkg::MAX_PIXELS) ?
                ws_pbe_pkg::CNT_W'(ws_pbe_pkg::MAX_PIXELS) : pix_cnt_q;
    pix_bits  = SW'(live_pix) * SW'(ws_pbe_pkg::BITS_PER_PIXEL);
    frame_len = SW'(lead_q) + SW'(trail_q) + pix_bits;
    slot_inc  = {1'b0, slot_q} + (SW + 1)'(1);
    is_last   = slot_inc >= {1'b0, frame_len};
    rel       = slot_q - SW'(lead_q);
    in_pix    = (slot_q >= SW'(lead_q)) && (rel < pix_bits) && (slot_q < frame_len);
    quot_prod = (2 * SW)'(rel[SW-1:3]) * (2 * SW)'(ws_pbe_pkg::RECIP3);
    pix_idx   = quot_prod[2*SW-1:ws_pbe_pkg::DIV_K];
    bit_full  = rel - pix_idx * SW'(ws_pbe_pkg::BITS_PER_PIXEL);
  end

  always_comb begin
    mem_req.wr_en   = accept && (data_i.opcode == ws_pbe_pkg::OP_WRITE) &&
                      (32'(data_i.pixel_index) < 32'(live_pix));
    mem_req.fill_en = accept && (data_i.opcode == ws_pbe_pkg::OP_FILL);
    mem_req.rd_en   = fetch_go;
    mem_req.wr_addr = ws_pbe_pkg::PIX_AW'(data_i.pixel_index);
    mem_req.rd_addr = pix_idx[ws_pbe_pkg::PIX_AW-1:0];
    mem_req.color   = data_i.color_grb;
  end

  ws_pbe_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mem_req),
    .color_o(color)
  );

  always_comb begin
    slot_d   = slot_q;
    active_d = active_q;
    if (accept && (data_i.opcode == ws_pbe_pkg::OP_START)) begin
      slot_d   = '0;
      active_d = (frame_len != '0);
    end else if (fetch_go && active_q) begin
      if (is_last) begin
        slot_d   = '0;
        active_d = 1'b0;
      end else begin
        slot_d = slot_inc[SW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_one_q  <= '0;
      duty_zero_q <= '0;
      pix_cnt_q   <= ws_pbe_pkg::CNT_W'(64);
      lead_q      <= '0;
      trail_q     <= 8'd48;
      slot_q      <= '0;
      active_q    <= 1'b0;
      pend_q      <= 1'b0;
      code_en_q   <= 1'b0;
      end_q       <= 1'b0;
      bit_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ws_pbe_pkg::REG_DUTY_ONE:    duty_one_q  <= cfg_wdata_i;
          ws_pbe_pkg::REG_DUTY_ZERO:   duty_zero_q <= cfg_wdata_i;
          ws_pbe_pkg::REG_PIXEL_COUNT: pix_cnt_q   <= cfg_wdata_i[ws_pbe_pkg::CNT_W-1:0];
          ws_pbe_pkg::REG_LEAD_SLOTS:  lead_q      <= cfg_wdata_i;
          ws_pbe_pkg::REG_TRAIL_SLOTS: trail_q     <= cfg_wdata_i;
          default: ;
        endcase
      end
      slot_q   <= slot_d;
      active_q <= active_d;
      pend_q   <= fetch_go;
      if (fetch_go) begin
        code_en_q <= active_q && in_pix;
        end_q     <= !active_q || is_last;
        bit_q     <= bit_full[4:0];
      end
    end
  end

  assign color_sh = color << bit_q;

  always_comb begin
    result_valid_o     = pend_q;
    result_o.frame_end = end_q;
    result_o.duty_code = '0;
    if (code_en_q) begin
      result_o.duty_code = color_sh[ws_pbe_pkg::COLOR_W-1] ? duty_one_q : duty_zero_q;
    end
  end

`ifndef ASSERT_OFF
  a_result_follows_fetch : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy && data_i.opcode == ws_pbe_pkg::OP_FETCH))
    else $error("result strobe without a fetch transfer");

  a_idle_fetch : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fetch_go && !active_q) |=>
      (result_valid_o && result_o.frame_end && result_o.duty_code == '0))
    else $error("idle fetch must give a gap code with frame end");

  a_idle_slot_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> (slot_q == '0))
    else $error("slot counter not cleared while idle");

  a_frame_end_stops : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fetch_go && active_q && is_last && data_i.opcode == ws_pbe_pkg::OP_FETCH) |=>
      (!active_q && result_o.frame_end))
    else $error("last slot did not end the frame");
`endif

endmodule

@@ dv/ws2812_pixel_bit_encoder_tb.sv @@
// Testbench for ws2812_pixel_bit_encoder: pixel writes, fills, frame starts and slot fetches,
// checked against a behavioral encoder model held in the bench, under several register settings.
// Depends on ws_pbe_pkg and the ws2812_pixel_bit_encoder RTL only.
module ws2812_pixel_bit_encoder_tb;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 1750;
  localparam int PHASES       = 12;
  localparam logic [ws_pbe_pkg::CFG_IDX_W-1:0] REG_UNUSED = ws_pbe_pkg::CFG_IDX_W'(7);

  logic                             clk_i;
  logic                             rst_ni;
  logic                             start;
  logic                             busy;
  ws_pbe_pkg::cmd_t                 data_i;
  logic                             result_valid_o;
  ws_pbe_pkg::result_t              result_o;
  logic                             cfg_we_i;
  logic [ws_pbe_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [7:0]                       cfg_wdata_i;

  ws2812_pixel_bit_encoder u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .data_i         (data_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  logic [ws_pbe_pkg::DUTY_W-1:0]  enc_duty_one;
  logic [ws_pbe_pkg::DUTY_W-1:0]  enc_duty_zero;
  logic [ws_pbe_pkg::CNT_W-1:0]   enc_pix_cnt;
  logic [7:0]                     enc_lead;
  logic [7:0]                     enc_trail;
  logic [ws_pbe_pkg::COLOR_W-1:0] enc_store [ws_pbe_pkg::MAX_PIXELS];
  logic                           enc_own [ws_pbe_pkg::MAX_PIXELS];
  logic [ws_pbe_pkg::COLOR_W-1:0] enc_fill;
  int unsigned                    enc_slot;
  logic                           enc_active;

  ws_pbe_pkg::result_t slot_q[$];
  int      errors = 0;
  int      n_sent = 0;
  int      idle_pct = 0;
  int      cycles = 0;
  int      phase_target = 0;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic int unsigned live_pixels();
    return (int'(enc_pix_cnt) > ws_pbe_pkg::MAX_PIXELS) ? ws_pbe_pkg::MAX_PIXELS :
           int'(enc_pix_cnt);
  endfunction

  function automatic int unsigned frame_len();
    return int'(enc_lead) + ws_pbe_pkg::BITS_PER_PIXEL * live_pixels() + int'(enc_trail);
  endfunction

  function automatic logic [ws_pbe_pkg::DUTY_W-1:0] bit_code(int unsigned rel);
    logic [ws_pbe_pkg::COLOR_W-1:0] c;
    int unsigned p;
    int unsigned b;
    p = rel / ws_pbe_pkg::BITS_PER_PIXEL;
    b = rel % ws_pbe_pkg::BITS_PER_PIXEL;
    c = enc_own[p] ? enc_store[p] : enc_fill;
    return c[ws_pbe_pkg::COLOR_W-1-b] ? enc_duty_one : enc_duty_zero;
  endfunction

  function automatic logic [ws_pbe_pkg::COLOR_W-1:0] rand_color();
    int r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return ws_pbe_pkg::COLOR_W'($urandom);
  endfunction

  function automatic logic [7:0] pick_duty();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'd255;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] pick_gap();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'd255;
    return 8'($urandom_range(12));
  endfunction

  function automatic logic [7:0] pick_count();
    int r;
    r = $urandom_range(19);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'd64;
    if (r == 2) return 8'($urandom_range(65, 255));
    if (r == 3) return 8'($urandom_range(5, 63));
    return 8'($urandom_range(1, 4));
  endfunction

  task automatic encoder_reset();
    enc_duty_one  = '0;
    enc_duty_zero = '0;
    enc_pix_cnt   = ws_pbe_pkg::CNT_W'(64);
    enc_lead      = 8'd0;
    enc_trail     = 8'd48;
    for (int i = 0; i < ws_pbe_pkg::MAX_PIXELS; i++) begin
      enc_store[i] = '0;
      enc_own[i]   = 1'b1;
    end
    enc_fill   = '0;
    enc_slot   = 0;
    enc_active = 1'b0;
  endtask

  task automatic encoder_cfg(logic [ws_pbe_pkg::CFG_IDX_W-1:0] idx, logic [7:0] val);
    case (idx)
      ws_pbe_pkg::REG_DUTY_ONE:    enc_duty_one  = val;
      ws_pbe_pkg::REG_DUTY_ZERO:   enc_duty_zero = val;
      ws_pbe_pkg::REG_PIXEL_COUNT: enc_pix_cnt   = val[ws_pbe_pkg::CNT_W-1:0];
      ws_pbe_pkg::REG_LEAD_SLOTS:  enc_lead      = val;
      ws_pbe_pkg::REG_TRAIL_SLOTS: enc_trail     = val;
      default: ;
    endcase
  endtask

  task automatic encoder_cmd(ws_pbe_pkg::cmd_t c);
    int unsigned         len;
    int unsigned         s;
    int unsigned         bits;
    logic                last;
    ws_pbe_pkg::result_t r;
    case (ws_pbe_pkg::ws_op_e'(c.opcode))
      ws_pbe_pkg::OP_WRITE: begin
        if (c.pixel_index < live_pixels()) begin
          enc_store[c.pixel_index] = c.color_grb;
          enc_own[c.pixel_index]   = 1'b1;
        end
      end
      ws_pbe_pkg::OP_FILL: begin
        enc_fill = c.color_grb;
        for (int i = 0; i < ws_pbe_pkg::MAX_PIXELS; i++) enc_own[i] = 1'b0;
      end
      ws_pbe_pkg::OP_START: begin
        enc_slot   = 0;
        enc_active = (frame_len() != 0);
      end
      ws_pbe_pkg::OP_FETCH: begin
        r.duty_code = '0;
        r.frame_end = 1'b1;
        if (enc_active) begin
          len  = frame_len();
          s    = enc_slot;
          bits = ws_pbe_pkg::BITS_PER_PIXEL * live_pixels();
          last = (len == 0) || (s >= len - 1);
          if (s >= enc_lead && s - enc_lead < bits && (!last || (len != 0 && s == len - 1)))
            r.duty_code = bit_code(s - enc_lead);
          if (last) begin
            enc_active = 1'b0;
            enc_slot   = 0;
          end else begin
            r.frame_end = 1'b0;
            enc_slot    = s + 1;
          end
        end
        slot_q.push_back(r);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin
    ws_pbe_pkg::result_t want;
    if (rst_ni) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("ws2812_pixel_bit_encoder_tb: done, errors");
        $finish;
      end
      if (start && busy === 1'b0) encoder_cmd(data_i);
      if (result_valid_o === 1'b1) begin
        if (slot_q.size() == 0) begin
          errors++;
          $error("unexpected result: duty_code %0d frame_end %0b",
                 result_o.duty_code, result_o.frame_end);
        end else begin
          want = slot_q.pop_front();
          if (result_o.duty_code !== want.duty_code) begin
            errors++;
            $error("duty_code: expected %0d, got %0d", want.duty_code, result_o.duty_code);
          end
          if (result_o.frame_end !== want.frame_end) begin
            errors++;
            $error("frame_end: expected %0b, got %0b", want.frame_end, result_o.frame_end);
          end
        end
      end
    end
  end

  task automatic send_cmd(ws_pbe_pkg::ws_op_e op, logic [5:0] idx,
                          logic [ws_pbe_pkg::COLOR_W-1:0] color);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start  <= 1'b1;
    data_i <= ws_pbe_pkg::cmd_t'{opcode: op, pixel_index: idx, color_grb: color};
    do @(posedge clk_i); while (busy !== 1'b0);
    n_sent++;
  endtask

  task automatic fetch_n(int n);
    repeat (n) send_cmd(ws_pbe_pkg::OP_FETCH, 6'($urandom_range(63)), rand_color());
  endtask

  task automatic settle();
    start <= 1'b0;
    while (slot_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [ws_pbe_pkg::CFG_IDX_W-1:0] idx, logic [7:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    encoder_cfg(idx, val);
  endtask

  task automatic set_config(logic [7:0] d1, logic [7:0] d0, logic [7:0] pc,
                            logic [7:0] ld, logic [7:0] tr);
    write_reg(ws_pbe_pkg::REG_DUTY_ONE, d1);
    write_reg(ws_pbe_pkg::REG_DUTY_ZERO, d0);
    write_reg(ws_pbe_pkg::REG_PIXEL_COUNT, pc);
    write_reg(ws_pbe_pkg::REG_LEAD_SLOTS, ld);
    write_reg(ws_pbe_pkg::REG_TRAIL_SLOTS, tr);
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_idle_fetch();
    fetch_n(2);
    send_cmd(ws_pbe_pkg::OP_START, 6'd0, '0);
    fetch_n(3);
    send_cmd(ws_pbe_pkg::OP_START, 6'd0, '0);
    fetch_n(2);
  endtask

  task automatic test_single_pixel();
    settle();
    set_config(8'hFF, 8'h00, 8'd1, 8'd0, 8'd0);
    send_cmd(ws_pbe_pkg::OP_WRITE, 6'd0, 24'h80_00_01);
    send_cmd(ws_pbe_pkg::OP_WRITE, 6'd63, 24'hFF_FF_FF);
    send_cmd(ws_pbe_pkg::OP_START, 6'd0, '0);
    fetch_n(25);
  endtask

  task automatic test_gaps_and_count();
    settle();
    set_config(8'h3C, 8'hC3, 8'd0, 8'd0, 8'd0);
    send_cmd(ws_pbe_pkg::OP_WRITE, 6'd0, 24'h12_34_56);
    send_cmd(ws_pbe_pkg::OP_START, 6'd0, '0);
    fetch_n(1);
    settle();
    write_reg(REG_UNUSED, 8'hFF);
    set_config(8'hA5, 8'h5A, 8'hFF, 8'd2, 8'd1);
    send_cmd(ws_pbe_pkg::OP_FILL, 6'd0, 24'hFF_FF_FF);
    send_cmd(ws_pbe_pkg::OP_START, 6'd0, '0);
    fetch_n(4);
    send_cmd(ws_pbe_pkg::OP_FILL, 6'd0, 24'h00_00_00);
    fetch_n(2);
  endtask

  task automatic test_live_change();
    settle();
    set_config(8'h55, 8'hAA, 8'd64, 8'd0, 8'd0);
    send_cmd(ws_pbe_pkg::OP_FILL, 6'd0, rand_color());
    send_cmd(ws_pbe_pkg::OP_START, 6'd0, '0);
    fetch_n(30);
    settle();
    set_config(8'h55, 8'hAA, 8'd1, 8'd0, 8'd0);
    fetch_n(2);
  endtask

  task automatic run_frame();
    int unsigned len;
    int unsigned k;
    int unsigned live;
    int unsigned left;
    live = live_pixels();
    if ($urandom_range(4) == 0)
      send_cmd(ws_pbe_pkg::OP_FILL, 6'($urandom_range(63)), rand_color());
    repeat ($urandom_range(0, 3)) begin
      if (live > 0 && $urandom_range(4) != 0)
        send_cmd(ws_pbe_pkg::OP_WRITE, 6'($urandom_range(live - 1)), rand_color());
      else
        send_cmd(ws_pbe_pkg::OP_WRITE, 6'($urandom_range(63)), rand_color());
    end
    send_cmd(ws_pbe_pkg::OP_START, 6'($urandom_range(63)), rand_color());
    len = frame_len();
    if (len == 0)
      k = $urandom_range(1, 2);
    else if (len > 600)
      k = $urandom_range(20, 200);
    else if ($urandom_range(3) == 0)
      k = $urandom_range(1, len);
    else
      k = len + $urandom_range(0, 2);
    left = (phase_target > n_sent) ? unsigned'(phase_target - n_sent) : 1;
    if (k > left) k = left;
    repeat (k) begin
      if ($urandom_range(99) < 4)
        send_cmd($urandom_range(1) ? ws_pbe_pkg::OP_WRITE : ws_pbe_pkg::OP_FILL,
                 6'($urandom_range(63)), rand_color());
      fetch_n(1);
    end
  endtask

  task automatic test_random();
    int pcts[3] = '{0, 46, 34};
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      idle_pct = pcts[ph % 3];
      if (ph == 0)
        set_config(8'hFF, 8'h00, 8'd1, 8'd255, 8'd255);
      else
        set_config(pick_duty(), pick_duty(), pick_count(), pick_gap(), pick_gap());
      phase_target = n_sent + RANDOM_ITEMS / PHASES;
      while (n_sent < phase_target) begin
        if ($urandom_range(99) < 75)
          run_frame();
        else
          send_cmd(ws_pbe_pkg::ws_op_e'($urandom_range(3)), 6'($urandom_range(63)),
                   rand_color());
      end
    end
    idle_pct = 0;
  endtask

  initial begin
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    data_i      <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= ws_pbe_pkg::REG_DUTY_ONE;
    cfg_wdata_i <= '0;
    encoder_reset();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_fetch();
    test_single_pixel();
    test_gaps_and_count();
    test_live_change();
    test_random();
    settle();
    if (errors == 0) begin
      $display("ws2812_pixel_bit_encoder_tb: done, clean");
    end else begin
      $display("ws2812_pixel_bit_encoder_tb: done, errors");
    end
    $finish;
  end

endmodule

@@ ws2812_pixel_bit_encoder.f @@
rtl/ws_pbe_pkg.sv
rtl/ws_pbe_store.sv
rtl/ws2812_pixel_bit_encoder.sv
dv/ws2812_pixel_bit_encoder_tb.sv
